>>> rtl/spfb_pkg.sv
// Shared constants and types for the strict priority FIFO bank.
// No dependencies; used by spfb_ram users and strict_priority_fifo_bank.
package spfb_pkg;

  // bank geometry
  localparam int LEVELS = 8;
  localparam int DEPTH  = 4;

  localparam int DATA_W  = 32;
  localparam int LVL_IN_W = 3;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = LVL_W + SLOT_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

endpackage

>>> rtl/spfb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/strict_priority_fifo_bank.sv
// Strict priority FIFO bank: one circular FIFO per level, entries in one RAM.
// Depends on spfb_pkg and spfb_ram.
//
// Path: a result is registered in the pending stage and then in the output
//   register, and waits in the pending stage while the output is stalled.
// Throughput: one transaction per cycle unless in_stall; the level pointers
//   sit in flops and the entry RAM is touched at most once per transaction
//   (write on enqueue, read on dequeue); read data lands in the pending stage.
// Reset (rst, synchronous): all levels empty, pointers zero, no result held.
//   Entry RAM contents are not cleared; an entry is only read once written.
module strict_priority_fifo_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic signed [spfb_pkg::DATA_W-1:0]   data_in,
  input  logic        [spfb_pkg::LVL_IN_W-1:0] level_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [spfb_pkg::DATA_W-1:0]   data_out,
  output logic        [spfb_pkg::LVL_IN_W-1:0] level_out,
  output logic        [1:0]                    status
);

  localparam int LEVELS = spfb_pkg::LEVELS;
  localparam int LVL_W  = spfb_pkg::LVL_W;
  localparam int SLOT_W = spfb_pkg::SLOT_W;
  localparam int CNT_W  = spfb_pkg::CNT_W;
  localparam int ADDR_W = spfb_pkg::ADDR_W;
  localparam int DATA_W = spfb_pkg::DATA_W;
  localparam int LIN_W  = spfb_pkg::LVL_IN_W;

  // per-level pointers and fill counts
  logic [SLOT_W-1:0] head  [LEVELS];
  logic [SLOT_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0]  cnt   [LEVELS];

  // pending stage (waits on RAM read data) and output register
  logic                p_valid;
  logic                p_from_ram;
  logic [LIN_W-1:0]    p_level;
  spfb_pkg::status_t   p_status;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [LIN_W-1:0]    out_level_r;
  spfb_pkg::status_t   out_status_r;

  logic              acc;
  logic              move;
  logic              lvl_in_range;
  logic [LVL_W-1:0]  enq_lvl;
  logic              enq_ok;
  logic              any_ne;
  logic [LVL_W-1:0]  deq_lvl;
  logic              do_enq;
  logic              do_deq;
  logic [DATA_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(spfb_pkg::DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  // handshake: pending stage drains into the output register
  assign move     = p_valid && (!out_valid_r || !out_stall);
  assign in_stall = p_valid && !move;
  assign acc      = in_valid && !in_stall;

  // enqueue target check
  assign lvl_in_range = (32'(level_in) < 32'(LEVELS));
  assign enq_lvl      = LVL_W'(level_in);
  assign enq_ok       = lvl_in_range && (cnt[enq_lvl] != CNT_W'(spfb_pkg::DEPTH));

  // priority encoder: lowest-numbered non-empty level
  always_comb begin
    any_ne  = 1'b0;
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        any_ne  = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  assign do_enq    = acc && (func == spfb_pkg::FUNC_ENQ) && enq_ok;
  assign do_deq    = acc && (func == spfb_pkg::FUNC_DEQ) && any_ne;
  assign ram_waddr = {enq_lvl, tail[enq_lvl]};
  assign ram_raddr = {deq_lvl, head[deq_lvl]};

  spfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (spfb_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_enq),
    .waddr (ram_waddr),
    .wdata (data_in),
    .re    (do_deq),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (do_enq) begin
        tail[enq_lvl] <= next_slot(tail[enq_lvl]);
        cnt[enq_lvl]  <= cnt[enq_lvl] + CNT_W'(1);
      end
      if (do_deq) begin
        head[deq_lvl] <= next_slot(head[deq_lvl]);
        cnt[deq_lvl]  <= cnt[deq_lvl] - CNT_W'(1);
      end
    end
  end

  // pending stage: status known at accept, data from the RAM's registered read port
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (acc) begin
      p_valid <= 1'b1;
    end else if (move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_from_ram <= do_deq;
      if (func == spfb_pkg::FUNC_ENQ) begin
        p_level  <= level_in;
        p_status <= enq_ok ? spfb_pkg::ST_INSERTED : spfb_pkg::ST_OVERFLOW;
      end else if (any_ne) begin
        p_level  <= LIN_W'(deq_lvl);
        p_status <= spfb_pkg::ST_REMOVED;
      end else begin
        p_level  <= '0;
        p_status <= spfb_pkg::ST_UNDERFLOW;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r   <= p_from_ram ? ram_rdata : '0;
      out_level_r  <= p_level;
      out_status_r <= p_status;
    end
  end

  assign out_valid = out_valid_r;
  assign data_out  = out_data_r;
  assign level_out = out_level_r;
  assign status    = out_status_r;

  // fill counts never pass the level depth
  generate
    for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
      a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
        cnt[g] <= CNT_W'(spfb_pkg::DEPTH))
        else $error("fill count above depth on a level");
    end
  endgenerate

  // a dequeue is reported as removed exactly when some level held an entry
  a_deq_status: assert property (@(posedge clk) disable iff (rst)
    (acc && (func == spfb_pkg::FUNC_DEQ)) |=>
      ((p_status == spfb_pkg::ST_REMOVED) == $past(any_ne)))
    else $error("dequeue status disagrees with fill counts");

  // a pending result that cannot drain keeps its contents
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !move) |=> (p_valid && $stable(p_level) && $stable(p_status)))
    else $error("pending result lost while output stalled");

endmodule
